// ===== design/ukcf_pkg.sv =====
// ----------------------------------------------------------------------------
// ukcf_pkg
// Shared types and constants for the UTF-8 kana case folder: codepoint
// ranges, the conversion mode and the token passed from decoder to encoder.
// ----------------------------------------------------------------------------
package ukcf_pkg;

    localparam int CP_W              = 21;
    localparam int QUEUE_DEPTH_DEF   = 4;

    localparam logic [CP_W-1:0] CP_HIRA_LO   = 21'h003040;
    localparam logic [CP_W-1:0] CP_HIRA_HI   = 21'h00309F;
    localparam logic [CP_W-1:0] CP_KATA_LO   = 21'h0030A0;
    localparam logic [CP_W-1:0] CP_KATA_HI   = 21'h0030FF;
    localparam logic [CP_W-1:0] KANA_SHIFT   = 21'h000060;
    localparam logic [CP_W-1:0] CP_MAX       = 21'h10FFFF;
    localparam logic [CP_W-1:0] CP_1B_MAX    = 21'h00007F;
    localparam logic [CP_W-1:0] CP_2B_MAX    = 21'h0007FF;
    localparam logic [CP_W-1:0] CP_3B_MAX    = 21'h00FFFF;

    // space and punctuation that keep the all-kana flag set
    localparam logic [CP_W-1:0] CP_SPACE      = 21'h000020;
    localparam logic [CP_W-1:0] CP_IDEO_SPACE = 21'h003000;
    localparam logic [CP_W-1:0] CP_IDEO_COMMA = 21'h003001;
    localparam logic [CP_W-1:0] CP_IDEO_STOP  = 21'h003002;
    localparam logic [CP_W-1:0] CP_CORNER_L   = 21'h00300C;
    localparam logic [CP_W-1:0] CP_CORNER_R   = 21'h00300D;
    localparam logic [CP_W-1:0] CP_FW_EXCL    = 21'h00FF01;
    localparam logic [CP_W-1:0] CP_FW_QUEST   = 21'h00FF1F;

    typedef enum logic {
        MODE_KATA_TO_HIRA = 1'b0,
        MODE_HIRA_TO_KATA = 1'b1
    } ukcf_mode_t;

    // one decoded codepoint on its way to the encoder
    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            kana;     // running flag after this codepoint
        logic            run_end;  // last codepoint caused by its input byte
        logic            str_end;  // its input byte ended the string
    } ukcf_token_t;

endpackage

// ===== design/ukcf_front.sv =====
// ----------------------------------------------------------------------------
// ukcf_front
// Byte acceptor and UTF-8 decoder. Gathers an unfinished sequence, emits one
// codepoint token per step and replays held bytes after a cut-off string end.
// ----------------------------------------------------------------------------
module ukcf_front
    import ukcf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // in_last
    output logic        q_push,
    output ukcf_token_t q_token,
    input  logic        q_full
);

    logic [7:0]      held_reg [3];
    logic [7:0]      held_next [3];
    logic [1:0]      held_cnt_reg, held_cnt_next;
    logic            flush_reg, flush_next;
    logic            kana_reg, kana_next;

    logic [7:0]      win [4];
    logic [2:0]      n_cur;
    logic            last_cur;
    logic [2:0]      need;
    logic [CP_W-1:0] cp_asm;
    logic [CP_W-1:0] tok_cp;
    logic            tok_valid;
    logic [2:0]      used;
    logic [2:0]      tok_rem;
    logic            accept;
    logic            go;
    logic            tok_kana;

    function automatic logic [2:0] lead_len(input logic [7:0] b);
        if (b[7] == 1'b0)            return 3'd1;
        else if (b[7:5] == 3'b110)   return 3'd2;
        else if (b[7:4] == 4'b1110)  return 3'd3;
        else if (b[7:3] == 5'b11110) return 3'd4;
        else                         return 3'd0;
    endfunction

    function automatic logic allowed_cp(input logic [CP_W-1:0] cp);
        return (cp >= CP_HIRA_LO && cp <= CP_KATA_HI) ||
               cp == CP_SPACE || cp == CP_IDEO_SPACE || cp == CP_IDEO_COMMA ||
               cp == CP_IDEO_STOP || cp == CP_CORNER_L || cp == CP_CORNER_R ||
               cp == CP_FW_EXCL || cp == CP_FW_QUEST;
    endfunction

    assign s_tready = !flush_reg && !q_full;
    assign accept   = s_tvalid && s_tready;
    assign go       = accept || (flush_reg && !q_full);

    // window: held bytes followed by the incoming byte (ignored while replaying)
    always_comb begin
        win[0]   = (held_cnt_reg == 2'd0) ? s_tdata : held_reg[0];
        win[1]   = (held_cnt_reg == 2'd1) ? s_tdata : held_reg[1];
        win[2]   = (held_cnt_reg == 2'd2) ? s_tdata : held_reg[2];
        win[3]   = s_tdata;
        n_cur    = flush_reg ? {1'b0, held_cnt_reg} : {1'b0, held_cnt_reg} + 3'd1;
        last_cur = flush_reg || s_tlast;
        need     = lead_len(win[0]);
    end

    always_comb begin
        case (need)
            3'd2:    cp_asm = {10'd0, win[0][4:0], win[1][5:0]};
            3'd3:    cp_asm = {5'd0, win[0][3:0], win[1][5:0], win[2][5:0]};
            3'd4:    cp_asm = {win[0][2:0], win[1][5:0], win[2][5:0], win[3][5:0]};
            default: cp_asm = {14'd0, win[0][6:0]};
        endcase
    end

    always_comb begin
        if (need == 3'd0) begin
            tok_valid = 1'b1;
            tok_cp    = '0;
            used      = 3'd1;
        end else if (n_cur >= need) begin
            tok_valid = 1'b1;
            tok_cp    = cp_asm;
            used      = need;
        end else if (last_cur) begin
            // cut-off sequence: lead gives NUL, rest replayed as leads
            tok_valid = 1'b1;
            tok_cp    = '0;
            used      = 3'd1;
        end else begin
            tok_valid = 1'b0;
            tok_cp    = '0;
            used      = 3'd0;
        end
        tok_rem  = n_cur - used;
        tok_kana = kana_reg && allowed_cp(tok_cp);
    end

    always_comb begin
        logic [2:0] idx;
        for (int k = 0; k < 3; k++) begin
            idx          = used + 3'(k);
            held_next[k] = win[idx[1:0]];
        end
        held_cnt_next = tok_rem[1:0];
        flush_next    = tok_valid && last_cur && (tok_rem != 3'd0);
        if (tok_valid && last_cur && tok_rem == 3'd0) begin
            kana_next = 1'b1;
        end else if (tok_valid) begin
            kana_next = tok_kana;
        end else begin
            kana_next = kana_reg;
        end
    end

    assign q_push          = go && tok_valid;
    assign q_token.cp      = tok_cp;
    assign q_token.kana    = tok_kana;
    assign q_token.run_end = !(last_cur && tok_rem != 3'd0);
    assign q_token.str_end = last_cur;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_cnt_reg <= 2'd0;
            flush_reg    <= 1'b0;
            kana_reg     <= 1'b1;
        end else if (go) begin
            held_cnt_reg <= held_cnt_next;
            flush_reg    <= flush_next;
            kana_reg     <= kana_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (go) begin
            for (int k = 0; k < 3; k++) begin
                held_reg[k] <= held_next[k];
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_flush_holds_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        flush_reg |-> (held_cnt_reg != 2'd0) && !s_tready)
        else $error("replay pending with no held bytes or input open");

    a_kana_restored: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tlast && tok_rem == 3'd0) |=> kana_reg)
        else $error("all-kana flag not restored at string end");
`endif

endmodule

// ===== design/ukcf_queue.sv =====
// ----------------------------------------------------------------------------
// ukcf_queue
// Small register FIFO between the decoder and the encoder.
// ----------------------------------------------------------------------------
module ukcf_queue #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             rvalid
);

    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]   mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               do_push, do_pop;

    assign full    = (count_reg == COUNT_W'(DEPTH));
    assign rvalid  = (count_reg != '0);
    assign rdata   = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && rvalid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + COUNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - COUNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== design/ukcf_back.sv =====
// ----------------------------------------------------------------------------
// ukcf_back
// Kana shift and shortest-form UTF-8 encoder. Emits one byte per transaction
// from the queue head into the output register; holds the mode register.
// ----------------------------------------------------------------------------
module ukcf_back
    import ukcf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    input  logic        q_valid,
    input  ukcf_token_t q_token,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [8] run_last, [15:9] zero
    output logic        m_tlast,   // string_end
    output logic [1:0]  m_tuser    // [0] byte_valid, [1] all_kana
);

    ukcf_mode_t      mode_reg;
    logic [1:0]      idx_reg, idx_next;
    logic            m_tvalid_reg, m_tvalid_next;
    logic [7:0]      byte_reg, byte_next;
    logic            run_last_reg, run_last_next;
    logic            str_end_reg, str_end_next;
    logic            bvalid_reg, bvalid_next;
    logic            kana_reg, kana_next;

    logic [CP_W-1:0] sc;
    logic [2:0]      enc_len;
    logic [7:0]      enc_byte;
    logic            out_free;
    logic            final_byte;
    logic            load;

    assign cfg_ready = 1'b1;

    always_comb begin
        sc = q_token.cp;
        if (mode_reg == MODE_KATA_TO_HIRA) begin
            if (q_token.cp >= CP_KATA_LO && q_token.cp <= CP_KATA_HI) begin
                sc = q_token.cp - KANA_SHIFT;
            end
        end else begin
            if (q_token.cp >= CP_HIRA_LO && q_token.cp <= CP_HIRA_HI) begin
                sc = q_token.cp + KANA_SHIFT;
            end
        end
        if (sc <= CP_1B_MAX)      enc_len = 3'd1;
        else if (sc <= CP_2B_MAX) enc_len = 3'd2;
        else if (sc <= CP_3B_MAX) enc_len = 3'd3;
        else if (sc <= CP_MAX)    enc_len = 3'd4;
        else                      enc_len = 3'd0;
    end

    always_comb begin
        case ({enc_len, idx_reg})
            {3'd1, 2'd0}: enc_byte = sc[7:0];
            {3'd2, 2'd0}: enc_byte = {3'b110, sc[10:6]};
            {3'd2, 2'd1}: enc_byte = {2'b10, sc[5:0]};
            {3'd3, 2'd0}: enc_byte = {4'b1110, sc[15:12]};
            {3'd3, 2'd1}: enc_byte = {2'b10, sc[11:6]};
            {3'd3, 2'd2}: enc_byte = {2'b10, sc[5:0]};
            {3'd4, 2'd0}: enc_byte = {5'b11110, sc[20:18]};
            {3'd4, 2'd1}: enc_byte = {2'b10, sc[17:12]};
            {3'd4, 2'd2}: enc_byte = {2'b10, sc[11:6]};
            {3'd4, 2'd3}: enc_byte = {2'b10, sc[5:0]};
            default:      enc_byte = 8'h00;
        endcase
    end

    assign out_free   = !m_tvalid_reg || m_tready;
    assign final_byte = ({1'b0, idx_reg} == enc_len - 3'd1);

    always_comb begin
        idx_next      = idx_reg;
        q_pop         = 1'b0;
        load          = 1'b0;
        byte_next     = byte_reg;
        run_last_next = run_last_reg;
        str_end_next  = str_end_reg;
        bvalid_next   = bvalid_reg;
        kana_next     = kana_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        if (q_valid) begin
            if (enc_len == 3'd0 && !q_token.str_end) begin
                // out of range, nothing to send
                q_pop = 1'b1;
            end else if (enc_len == 3'd0 && out_free) begin
                // bare end marker
                q_pop         = 1'b1;
                load          = 1'b1;
                byte_next     = 8'h00;
                bvalid_next   = 1'b0;
                run_last_next = 1'b1;
                str_end_next  = 1'b1;
                kana_next     = q_token.kana;
            end else if (enc_len != 3'd0 && out_free) begin
                load          = 1'b1;
                byte_next     = enc_byte;
                bvalid_next   = 1'b1;
                run_last_next = q_token.run_end && final_byte;
                str_end_next  = q_token.run_end && final_byte && q_token.str_end;
                kana_next     = q_token.kana;
                if (final_byte) begin
                    q_pop    = 1'b1;
                    idx_next = 2'd0;
                end else begin
                    idx_next = idx_reg + 2'd1;
                end
            end
        end
        if (load) begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_KATA_TO_HIRA;
            idx_reg      <= 2'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                mode_reg <= ukcf_mode_t'(cfg_data);
            end
            idx_reg      <= idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg     <= byte_next;
        run_last_reg <= run_last_next;
        str_end_reg  <= str_end_next;
        bvalid_reg   <= bvalid_next;
        kana_reg     <= kana_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, run_last_reg, byte_reg};
    assign m_tlast  = str_end_reg;
    assign m_tuser  = {kana_reg, bvalid_reg};

`ifndef NO_ASSERTIONS
    a_mid_token_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (idx_reg != 2'd0) |-> q_valid && (enc_len > {1'b0, idx_reg}))
        else $error("encoder mid-sequence without a matching token");

    a_marker_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !bvalid_reg) |-> str_end_reg && run_last_reg)
        else $error("bare marker not flagged as string end");
`endif

endmodule

// ===== design/utf8_kana_case_folder_core.sv =====
// ----------------------------------------------------------------------------
// utf8_kana_case_folder_core
// Path: decoder, token queue, then encoder into the output register.
// Throughput: one input byte per cycle while output bytes keep pace; a
// string cut off mid sequence holds the input while the held bytes are
// replayed as further codepoints.
// Reset: synchronous, active low; no clearing pass, ready the cycle after.
// ----------------------------------------------------------------------------
module utf8_kana_case_folder_core
    import ukcf_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // in_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [8] run_last, [15:9] zero
    output logic        m_tlast,   // string_end
    output logic [1:0]  m_tuser,   // [0] byte_valid, [1] all_kana
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data   // conv_mode
);

    ukcf_token_t push_token;
    ukcf_token_t head_token;
    logic        q_push;
    logic        q_full;
    logic        q_pop;
    logic        q_valid;

    ukcf_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_push   (q_push),
        .q_token  (push_token),
        .q_full   (q_full)
    );

    ukcf_queue #(
        .WIDTH ($bits(ukcf_token_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (push_token),
        .full    (q_full),
        .pop     (q_pop),
        .rdata   (head_token),
        .rvalid  (q_valid)
    );

    ukcf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_token   (head_token),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule
